[design/assert_macros.svh]
// ----------------------------------------------------------------------------
// Assertion macros
// Shared concurrent assertion wrappers, clocked on aclk and held off in reset.
// ----------------------------------------------------------------------------
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH
`ifndef SYNTHESIS
// Condition that must hold at every clock edge out of reset.
`define ASSERT_ALWAYS(label, cond, msg) \
    label: assert property (@(posedge aclk) disable iff (!aresetn) (cond)) \
        else $error(msg);
// Same-cycle implication.
`define ASSERT_IMPLY(label, ante, cons, msg) \
    label: assert property (@(posedge aclk) disable iff (!aresetn) (ante) |-> (cons)) \
        else $error(msg);
// Next-cycle implication.
`define ASSERT_NEXT(label, ante, cons, msg) \
    label: assert property (@(posedge aclk) disable iff (!aresetn) (ante) |=> (cons)) \
        else $error(msg);
`else
`define ASSERT_ALWAYS(label, cond, msg)
`define ASSERT_IMPLY(label, ante, cons, msg)
`define ASSERT_NEXT(label, ante, cons, msg)
`endif
`endif

[design/ils_pkg.sv]
// ----------------------------------------------------------------------------
// ils_pkg
// Request codes, status codes, field widths and the cell control type.
// ----------------------------------------------------------------------------
package ils_pkg;

    localparam int OP_W    = 3;
    localparam int POS_W   = 16;
    localparam int VAL_W   = 32;
    localparam int ST_W    = 2;
    localparam int LEN_W   = 11;
    localparam int IN_W    = 56;
    localparam int OUT_W   = 48;

    typedef enum logic [OP_W-1:0] {
        OP_READ       = 3'd0,
        OP_PUSH_FRONT = 3'd1,
        OP_PUSH_BACK  = 3'd2,
        OP_INSERT_AT  = 3'd3,
        OP_REMOVE_AT  = 3'd4
    } op_t;

    typedef enum logic [ST_W-1:0] {
        ST_DONE    = 2'd0,
        ST_BAD_POS = 2'd1,
        ST_FULL    = 2'd2
    } status_t;

    // Per-cell update selection for one beat.
    typedef struct packed {
        logic load_new;
        logic take_left;
        logic take_right;
    } cell_ctrl_t;

endpackage

[design/ils_cell.sv]
// ----------------------------------------------------------------------------
// ils_cell
// One list slot: holds its value, or takes the new value or a neighbor's.
// ----------------------------------------------------------------------------
module ils_cell (
    input  logic                        aclk,
    input  ils_pkg::cell_ctrl_t         ctrl,
    input  logic [ils_pkg::VAL_W-1:0]   new_val,
    input  logic [ils_pkg::VAL_W-1:0]   left_val,
    input  logic [ils_pkg::VAL_W-1:0]   right_val,
    output logic [ils_pkg::VAL_W-1:0]   val_out
);
    import ils_pkg::*;

    logic [VAL_W-1:0] val_reg;
    logic [VAL_W-1:0] val_next;

    // Insert shifts toward higher positions, delete toward lower ones.
    always_comb begin
        val_next = val_reg;
        if (ctrl.load_new) begin
            val_next = new_val;
        end else if (ctrl.take_left) begin
            val_next = left_val;
        end else if (ctrl.take_right) begin
            val_next = right_val;
        end
    end

    always_ff @(posedge aclk) begin
        val_reg <= val_next;
    end

    assign val_out = val_reg;

endmodule

[design/indexed_list_store.sv]
// An accepted beat is held in the request stage, and its result is registered in
// the result stage onto m_tdata; no new request is taken while one is held, and
// the held request stays while the row of cells updates and the read selection is formed.
// The input is taken while an earlier result still waits on the master side.
// Reset: aresetn (synchronous, active low) empties the list; cell contents are
// not cleared, since only positions below the count are ever read.
// ----------------------------------------------------------------------------
// indexed_list_store
// Ordered list of signed words with read, insert and delete by position.
// ----------------------------------------------------------------------------
module indexed_list_store #(
    parameter int CAPACITY = 64
) (
    input  logic                        aclk,
    input  logic                        aresetn,
    input  logic                        s_tvalid,
    output logic                        s_tready,
    // req_type[2:0], position[18:3], item_value[50:19], zero pad[55:51]
    input  logic [ils_pkg::IN_W-1:0]    s_tdata,
    output logic                        m_tvalid,
    input  logic                        m_tready,
    // read_value[31:0], status[33:32], length_now[44:34], zero pad[47:45]
    output logic [ils_pkg::OUT_W-1:0]   m_tdata
);
    import ils_pkg::*;

    localparam int CNT_W = $clog2(CAPACITY + 1);

    // Request stage.
    logic               req_valid_reg;
    logic               req_valid_next;
    logic [OP_W-1:0]    req_op_reg;
    logic [POS_W-1:0]   req_pos_reg;
    logic [VAL_W-1:0]   req_val_reg;

    // List length.
    logic [CNT_W-1:0]   count_reg;
    logic [CNT_W-1:0]   count_next;

    // Result stage.
    logic               out_valid_reg;
    logic               out_valid_next;
    logic [VAL_W-1:0]   out_rv_reg;
    logic [ST_W-1:0]    out_st_reg;
    logic [LEN_W-1:0]   out_len_reg;

    logic               s_beat;
    logic               exec;
    logic               full;
    logic [POS_W-1:0]   cnt_pos;
    logic               ins;
    logic               del;
    logic [POS_W-1:0]   ins_pos;
    logic [VAL_W-1:0]   rv;
    status_t            st;
    logic [VAL_W-1:0]   rd_data;

    cell_ctrl_t         cell_ctrl [CAPACITY];
    logic [VAL_W-1:0]   cell_val  [CAPACITY];

    assign s_tready = !req_valid_reg;
    assign s_beat   = s_tvalid && s_tready;
    assign exec     = req_valid_reg && (!out_valid_reg || m_tready);
    assign full     = (count_reg >= CNT_W'(CAPACITY));
    assign cnt_pos  = POS_W'(count_reg);

    // Decode the held request against the current length.
    always_comb begin
        ins     = 1'b0;
        del     = 1'b0;
        ins_pos = '0;
        rv      = '1;
        st      = ST_DONE;
        unique case (op_t'(req_op_reg))
            OP_READ: begin
                if (req_pos_reg < cnt_pos) begin
                    rv = rd_data;
                end else begin
                    st = ST_BAD_POS;
                end
            end
            OP_PUSH_FRONT: begin
                if (full) begin
                    st = ST_FULL;
                end else begin
                    ins = 1'b1;
                end
            end
            OP_PUSH_BACK: begin
                if (full) begin
                    st = ST_FULL;
                end else begin
                    ins     = 1'b1;
                    ins_pos = cnt_pos;
                end
            end
            OP_INSERT_AT: begin
                if (req_pos_reg > cnt_pos) begin
                    st = ST_BAD_POS;
                end else if (full) begin
                    st = ST_FULL;
                end else begin
                    ins     = 1'b1;
                    ins_pos = req_pos_reg;
                end
            end
            OP_REMOVE_AT: begin
                if (req_pos_reg < cnt_pos) begin
                    del = 1'b1;
                end else begin
                    st = ST_BAD_POS;
                end
            end
            default: begin
                st = ST_BAD_POS;
            end
        endcase
    end

    // New length after this request.
    always_comb begin
        count_next = count_reg;
        if (exec && ins) begin
            count_next = count_reg + CNT_W'(1);
        end else if (exec && del) begin
            count_next = count_reg - CNT_W'(1);
        end
    end

    // Row of cells; each one looks at its neighbors on either side.
    for (genvar k = 0; k < CAPACITY; k++) begin : g_cell
        localparam logic [POS_W-1:0] K = POS_W'(k);
        logic [VAL_W-1:0] left_v;
        logic [VAL_W-1:0] right_v;

        assign left_v  = (k == 0) ? req_val_reg : cell_val[(k == 0) ? 0 : k - 1];
        assign right_v = (k == CAPACITY - 1) ? cell_val[k]
                                             : cell_val[(k == CAPACITY - 1) ? k : k + 1];

        assign cell_ctrl[k].load_new   = exec && ins && (K == ins_pos);
        assign cell_ctrl[k].take_left  = exec && ins && (K > ins_pos);
        assign cell_ctrl[k].take_right = exec && del && (K >= req_pos_reg);

        ils_cell u_cell (
            .aclk      (aclk),
            .ctrl      (cell_ctrl[k]),
            .new_val   (req_val_reg),
            .left_val  (left_v),
            .right_val (right_v),
            .val_out   (cell_val[k])
        );
    end

    // Read selection: each cell contributes only when its position matches.
    always_comb begin
        rd_data = '0;
        for (int k = 0; k < CAPACITY; k++) begin
            if (req_pos_reg == POS_W'(k)) begin
                rd_data = rd_data | cell_val[k];
            end
        end
    end

    // Handshake control.
    always_comb begin
        req_valid_next = req_valid_reg;
        if (exec) begin
            req_valid_next = 1'b0;
        end
        if (s_beat) begin
            req_valid_next = 1'b1;
        end
        out_valid_next = out_valid_reg;
        if (m_tready) begin
            out_valid_next = 1'b0;
        end
        if (exec) begin
            out_valid_next = 1'b1;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            req_valid_reg <= 1'b0;
            out_valid_reg <= 1'b0;
            count_reg     <= '0;
        end else begin
            req_valid_reg <= req_valid_next;
            out_valid_reg <= out_valid_next;
            count_reg     <= count_next;
        end
    end

    // Payload registers.
    always_ff @(posedge aclk) begin
        if (s_beat) begin
            req_op_reg  <= s_tdata[OP_W-1:0];
            req_pos_reg <= s_tdata[OP_W+POS_W-1:OP_W];
            req_val_reg <= s_tdata[OP_W+POS_W+VAL_W-1:OP_W+POS_W];
        end
        if (exec) begin
            out_rv_reg  <= rv;
            out_st_reg  <= st;
            out_len_reg <= LEN_W'(count_next);
        end
    end

    assign m_tvalid = out_valid_reg;
    assign m_tdata  = {{(OUT_W - LEN_W - ST_W - VAL_W){1'b0}},
                       out_len_reg, out_st_reg, out_rv_reg};

    `include "assert_macros.svh"

    `ASSERT_ALWAYS(a_count_bound, count_reg <= CNT_W'(CAPACITY), "length above capacity")
    `ASSERT_IMPLY(a_full_len, out_valid_reg && (out_st_reg == ST_FULL), out_len_reg == LEN_W'(CAPACITY), "full status with room left")
    `ASSERT_IMPLY(a_fail_novalue, out_valid_reg && (out_st_reg != ST_DONE), out_rv_reg == '1, "failed request carries a value")
    `ASSERT_NEXT(a_exec_result, exec, out_valid_reg && !req_valid_reg, "executed request gave no result")

endmodule
